[src/wamt_pkg.sv]
`timescale 1ns / 1ps
// shared widths, state encoding and divider request type for the
// windowed average and max tracker; no dependencies
package wamt_pkg;

  // window depth and derived widths
  localparam int WINDOW = 64;
  localparam int TIME_W = 48;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = TIME_W + SLOT_W;
  localparam int DEN_W  = $clog2(WINDOW + 1);
  localparam int CNT_W  = $clog2(SUM_W + 1);

  // beat widths, padded to whole bytes
  localparam int IN_W   = 2 * TIME_W;
  localparam int OUT_RAW_W = 2 * TIME_W + 1;
  localparam int OUT_W  = ((OUT_RAW_W + 7) / 8) * 8;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  // request to the sequential divider
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

endpackage

[src/wamt_ring.sv]
`timescale 1ns / 1ps
// sample ring storage: one write port, one read port with registered data
// depends on wamt_pkg
module wamt_ring (
  input  logic                        clk,
  input  logic [wamt_pkg::SLOT_W-1:0] rd_addr,
  output logic [wamt_pkg::TIME_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [wamt_pkg::SLOT_W-1:0] wr_addr,
  input  logic [wamt_pkg::TIME_W-1:0] wr_data
);

  logic [wamt_pkg::TIME_W-1:0] mem [wamt_pkg::WINDOW];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[src/wamt_div.sv]
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, for sum / sample count
// depends on wamt_pkg
module wamt_div (
  input  logic                       clk,
  input  logic                       rst,
  input  wamt_pkg::div_req_t         req,
  output logic                       done,
  output logic [wamt_pkg::SUM_W-1:0] quotient
);

  logic [wamt_pkg::DEN_W-1:0] rem;
  logic [wamt_pkg::DEN_W-1:0] den;
  logic [wamt_pkg::CNT_W-1:0] cnt;
  logic                       busy;
  logic [wamt_pkg::DEN_W:0]   trial;
  logic                       fits;
  logic [wamt_pkg::DEN_W:0]   diff;

  // shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, quotient[wamt_pkg::SUM_W-1]};
    fits  = (trial >= {1'b0, den});
    diff  = trial - {1'b0, den};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= wamt_pkg::CNT_W'(wamt_pkg::SUM_W);
      end else if (busy) begin
        cnt <= cnt - wamt_pkg::CNT_W'(1);
        if (cnt == wamt_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= '0;
      den      <= req.den;
      quotient <= req.num;
    end else if (busy) begin
      rem      <= fits ? diff[wamt_pkg::DEN_W-1:0] : trial[wamt_pkg::DEN_W-1:0];
      quotient <= {quotient[wamt_pkg::SUM_W-2:0], fits};
    end
  end

endmodule

[src/windowed_average_and_max_tracker_unit.sv]
`timescale 1ns / 1ps
// windowed average and max tracker: one result beat per input beat.
// each input beat passes the read, update, divide and done steps; the
// restoring divider works through the 54-bit running sum, and the done step
// hands the result to the output register. one item is in flight at a time:
// a new input beat is taken only after that hand-over, which waits while a
// result beat is unsent. reset clears sum, slot, wrap flag, peak and the
// output valid; ring entries are left as they are and only read once written.
module windowed_average_and_max_tracker_unit (
  input  logic                       clk,
  input  logic                       rst,
  // input beat: start_time [47:0], done_time [95:48]
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [wamt_pkg::IN_W-1:0]  s_axis_tdata,
  // result beat: average_time [47:0], maximum_time [95:48], window_full [96]
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [wamt_pkg::OUT_W-1:0] m_axis_tdata
);

  wamt_pkg::state_t state, state_next;

  logic [wamt_pkg::TIME_W-1:0] start_time;
  logic [wamt_pkg::TIME_W-1:0] done_time;
  logic [wamt_pkg::TIME_W-1:0] elapsed, elapsed_next;
  logic [wamt_pkg::SUM_W-1:0]  sum, sum_next;
  logic [wamt_pkg::SLOT_W-1:0] slot, slot_next;
  logic                        wrapped, wrapped_next;
  logic [wamt_pkg::TIME_W-1:0] peak, peak_next;
  logic [wamt_pkg::SUM_W-1:0]  sum_add;

  logic [wamt_pkg::TIME_W-1:0] average_time;
  logic [wamt_pkg::TIME_W-1:0] maximum_time;
  logic                        window_full;
  logic                        out_load;

  logic [wamt_pkg::TIME_W-1:0] rd_data;
  logic                        wr_en;
  wamt_pkg::div_req_t          div_req;
  logic                        div_done;
  logic [wamt_pkg::SUM_W-1:0]  quotient;

  logic in_beat;

  assign start_time = s_axis_tdata[wamt_pkg::TIME_W-1:0];
  assign done_time  = s_axis_tdata[2*wamt_pkg::TIME_W-1:wamt_pkg::TIME_W];
  assign in_beat    = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == wamt_pkg::ST_IDLE);
  assign sum_add = sum + wamt_pkg::SUM_W'(elapsed);

  // sample ring, always reading the current slot
  wamt_ring u_ring (
    .clk     (clk),
    .rd_addr (slot),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (slot),
    .wr_data (elapsed)
  );

  // sequential divider for the average
  wamt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (quotient)
  );

  // next state and datapath updates
  always_comb begin
    state_next   = state;
    elapsed_next = elapsed;
    sum_next     = sum;
    slot_next    = slot;
    wrapped_next = wrapped;
    peak_next    = peak;
    wr_en        = 1'b0;
    out_load     = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = sum_add;
    div_req.den   = wrapped ? wamt_pkg::DEN_W'(wamt_pkg::WINDOW)
                            : wamt_pkg::DEN_W'(slot) + wamt_pkg::DEN_W'(1);
    case (state)
      wamt_pkg::ST_IDLE: begin
        if (in_beat) begin
          // elapsed time saturates at zero when done precedes start
          elapsed_next = (done_time >= start_time) ? (done_time - start_time) : '0;
          state_next   = wamt_pkg::ST_READ;
        end
      end
      wamt_pkg::ST_READ: begin
        // take the oldest sample out once the ring has wrapped
        if (wrapped) begin
          sum_next = sum - wamt_pkg::SUM_W'(rd_data);
        end
        state_next = wamt_pkg::ST_UPDATE;
      end
      wamt_pkg::ST_UPDATE: begin
        wr_en         = 1'b1;
        sum_next      = sum_add;
        div_req.start = 1'b1;
        if (elapsed > peak) begin
          peak_next = elapsed;
        end
        if (slot == wamt_pkg::SLOT_W'(wamt_pkg::WINDOW - 1)) begin
          slot_next    = '0;
          wrapped_next = 1'b1;
        end else begin
          slot_next = slot + wamt_pkg::SLOT_W'(1);
        end
        state_next = wamt_pkg::ST_DIVIDE;
      end
      wamt_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_next = wamt_pkg::ST_DONE;
        end
      end
      wamt_pkg::ST_DONE: begin
        // hand over once the output register is free
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = wamt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wamt_pkg::ST_IDLE;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= wamt_pkg::ST_IDLE;
      sum     <= '0;
      slot    <= '0;
      wrapped <= 1'b0;
      peak    <= '0;
    end else begin
      state   <= state_next;
      sum     <= sum_next;
      slot    <= slot_next;
      wrapped <= wrapped_next;
      peak    <= peak_next;
    end
  end

  always_ff @(posedge clk) begin
    elapsed <= elapsed_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      average_time <= quotient[wamt_pkg::TIME_W-1:0];
      maximum_time <= peak;
      window_full  <= wrapped;
    end
  end

  assign m_axis_tdata = {{(wamt_pkg::OUT_W - wamt_pkg::OUT_RAW_W){1'b0}},
                         window_full, maximum_time, average_time};

  // the wrap flag never clears outside reset
  assert property (@(posedge clk) disable iff (rst) wrapped |=> wrapped)
    else $error("wrap flag cleared");

  // the peak never decreases
  assert property (@(posedge clk) disable iff (rst) 1'b1 |=> peak >= $past(peak))
    else $error("peak decreased");

  // the divider only finishes while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == wamt_pkg::ST_DIVIDE)
    else $error("divider finished out of sequence");

  // a pending result is held until the output register frees up
  assert property (@(posedge clk) disable iff (rst)
    (state == wamt_pkg::ST_DONE && m_axis_tvalid && !m_axis_tready)
      |=> state == wamt_pkg::ST_DONE)
    else $error("result overwrote an unsent beat");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// self-checking bench for the windowed average and max tracker: sends stall
// timestamp beats, predicts each report beat and compares it field by field
// depends on wamt_pkg and windowed_average_and_max_tracker_unit
module testbench;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 840;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [wamt_pkg::TIME_W-1:0] TIME_MAX = '1;

  // one report beat as the block should produce it
  typedef struct packed {
    logic [wamt_pkg::TIME_W-1:0] average;
    logic [wamt_pkg::TIME_W-1:0] maximum;
    logic                        full;
  } report_t;

  // running window of stall times and the reports still owed
  class stall_average_board;
    logic [wamt_pkg::TIME_W-1:0] ring [wamt_pkg::WINDOW];
    logic [wamt_pkg::SUM_W-1:0]  window_sum;
    logic [wamt_pkg::SLOT_W-1:0] slot;
    bit                          wrapped;
    logic [wamt_pkg::TIME_W-1:0] peak;
    report_t                     expected_reports [$];
    int unsigned                 errors;

    function new();
      window_sum = '0;
      slot       = '0;
      wrapped    = 1'b0;
      peak       = '0;
      errors     = 0;
    endfunction

    // work out the report for one accepted stall beat
    function void record_stall(logic [wamt_pkg::TIME_W-1:0] t_start,
                               logic [wamt_pkg::TIME_W-1:0] t_done);
      logic [wamt_pkg::TIME_W-1:0] elapsed;
      logic [wamt_pkg::SUM_W-1:0]  divisor;
      logic [wamt_pkg::SUM_W-1:0]  quotient;
      report_t                     rep;
      // done before start counts as a zero-length stall
      elapsed = (t_done >= t_start) ? t_done - t_start : '0;
      // once wrapped, the oldest sample leaves the sum
      if (wrapped) begin
        window_sum = window_sum - wamt_pkg::SUM_W'(ring[slot]);
        divisor    = wamt_pkg::SUM_W'(wamt_pkg::WINDOW);
      end else begin
        divisor = wamt_pkg::SUM_W'(slot) + wamt_pkg::SUM_W'(1);
      end
      ring[slot] = elapsed;
      // peak only moves on a strictly longer stall
      if (elapsed > peak) begin
        peak = elapsed;
      end
      window_sum = window_sum + wamt_pkg::SUM_W'(elapsed);
      quotient   = window_sum / divisor;
      if (slot == wamt_pkg::SLOT_W'(wamt_pkg::WINDOW - 1)) begin
        slot    = '0;
        wrapped = 1'b1;
      end else begin
        slot = slot + wamt_pkg::SLOT_W'(1);
      end
      rep.average = quotient[wamt_pkg::TIME_W-1:0];
      rep.maximum = peak;
      rep.full    = wrapped;
      expected_reports.push_back(rep);
    endfunction

    // compare one accepted report beat with the oldest prediction
    function void check_report(logic [wamt_pkg::OUT_W-1:0] data);
      report_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: report beat with nothing expected, actual %h", $time, data);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      if (data[wamt_pkg::TIME_W-1:0] !== want.average) begin
        $display("%0t: average_time expected %h actual %h",
                 $time, want.average, data[wamt_pkg::TIME_W-1:0]);
        errors++;
      end
      if (data[2*wamt_pkg::TIME_W-1:wamt_pkg::TIME_W] !== want.maximum) begin
        $display("%0t: maximum_time expected %h actual %h",
                 $time, want.maximum, data[2*wamt_pkg::TIME_W-1:wamt_pkg::TIME_W]);
        errors++;
      end
      if (data[2*wamt_pkg::TIME_W] !== want.full) begin
        $display("%0t: window_full expected %b actual %b",
                 $time, want.full, data[2*wamt_pkg::TIME_W]);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [wamt_pkg::IN_W-1:0]  s_axis_tdata;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [wamt_pkg::OUT_W-1:0] m_axis_tdata;

  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;
  int unsigned        cycle_count;
  stall_average_board board;

  windowed_average_and_max_tracker_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watch both sides for accepted beats
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        board.record_stall(s_axis_tdata[wamt_pkg::TIME_W-1:0],
                           s_axis_tdata[2*wamt_pkg::TIME_W-1:wamt_pkg::TIME_W]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        board.check_report(m_axis_tdata);
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic logic [wamt_pkg::TIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[wamt_pkg::TIME_W-1:0];
  endfunction

  function automatic logic [wamt_pkg::TIME_W-1:0] add_clamped(
    logic [wamt_pkg::TIME_W-1:0] a,
    logic [wamt_pkg::TIME_W-1:0] b);
    logic [wamt_pkg::TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[wamt_pkg::TIME_W] ? TIME_MAX : s[wamt_pkg::TIME_W-1:0];
  endfunction

  // one stall beat, with optional idle cycles ahead of it
  task automatic send_stall(input logic [wamt_pkg::TIME_W-1:0] t_start,
                            input logic [wamt_pkg::TIME_W-1:0] t_done);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t_done, t_start};
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
  endtask

  // hold the sender until every owed report has come back
  task automatic wait_for_reports();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (board.expected_reports.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // random stall of a randomly chosen shape
  task automatic send_random_stall();
    logic [wamt_pkg::TIME_W-1:0] t_start;
    logic [wamt_pkg::TIME_W-1:0] t_done;
    logic [wamt_pkg::TIME_W-1:0] headroom;
    int unsigned                 shape;
    shape   = $urandom_range(99);
    t_start = rand_time();
    if (shape < 30) begin
      // short stall
      t_done = add_clamped(t_start, wamt_pkg::TIME_W'($urandom_range(20'hfffff)));
    end else if (shape < 45) begin
      // unrelated timestamps, half of them reversed
      t_done = rand_time();
    end else if (shape < 55) begin
      // done slightly before start
      t_done = t_start - wamt_pkg::TIME_W'($urandom_range(1000));
      if (t_done > t_start) begin
        t_done = '0;
      end
    end else if (shape < 62) begin
      t_done = t_start;
    end else if (shape < 72) begin
      // exactly the current peak
      headroom = TIME_MAX - board.peak;
      if (headroom != TIME_MAX) begin
        t_start = t_start % (headroom + 1'b1);
      end
      t_done = t_start + board.peak;
    end else if (shape < 85) begin
      // very long stall near the top of the range
      t_start = wamt_pkg::TIME_W'($urandom_range(16'hffff));
      t_done  = TIME_MAX - wamt_pkg::TIME_W'($urandom_range(16'hffff));
    end else begin
      // medium stall
      t_done = add_clamped(t_start, wamt_pkg::TIME_W'($urandom));
    end
    send_stall(t_start, t_done);
  endtask

  // stimulus
  initial begin
    board         = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    send_idle_pct = 10;
    recv_idle_pct = 73;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: range extremes, reversed times and ties with the peak
    send_stall('0, '0);
    send_stall(48'd100, 48'd1100);
    send_stall(TIME_MAX, '0);
    send_stall(48'd5000, 48'd4999);
    send_stall('0, TIME_MAX);
    send_stall(48'd1, TIME_MAX);
    send_stall('0, TIME_MAX);
    send_stall(TIME_MAX, TIME_MAX);
    send_stall(48'h5555_5555_5555, 48'haaaa_aaaa_aaaa);
    send_stall(48'haaaa_aaaa_aaaa, 48'h5555_5555_5555);
    send_stall(48'h0000_ffff_ffff, 48'hffff_0000_0000);
    send_stall(48'hffff_0000_0000, 48'hffff_0000_0001);
    send_stall(48'd12345, 48'd12352);
    send_stall(TIME_MAX - 1'b1, TIME_MAX);

    // random, three idling regimes with a full drain in between
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        wait_for_reports();
        send_idle_pct = 73;
        recv_idle_pct = 10;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        wait_for_reports();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (i == RANDOM_ITEMS / 6) begin
        wait_for_reports();
      end
      send_random_stall();
    end

    wait_for_reports();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.expected_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
